// File: sv/mvma_pkg.sv
package mvma_pkg;

  // Field widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned S_DATA_W  = 48;

  localparam int unsigned DEFAULT_MAX_LENGTH = 1024;
  localparam int unsigned OUT_DEPTH          = 8;

  localparam logic signed [DATA_W-1:0] GAIN_RESET = 16'sd4096;
  localparam logic [LEN_W-1:0]         LEN_RESET  = 11'd1024;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA  = 2'd0,
    REG_BETA   = 2'd1,
    REG_LENGTH = 2'd2
  } cfg_reg_t;

  // Request kinds
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_MATRIX = 1'b1
  } action_t;

  // Finished row handed from the MAC pipeline to the epilogue
  typedef struct packed {
    logic                     valid;
    logic signed [ACC_W-1:0]  acc;
    logic signed [DATA_W-1:0] self_value;
  } row_sum_t;

  // Rounded and clipped result handed to the output queue
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] y_value;
    logic                     saturated;
  } result_t;

  // Longest row the column counter must reach
  function automatic int unsigned len_cap(input int unsigned max_len);
    int unsigned top_len;
    top_len = (1 << LEN_W) - 1;
    return (max_len < top_len) ? max_len : top_len;
  endfunction

  function automatic int unsigned bits_for(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: sv/mvma_core.sv
module mvma_core
  import mvma_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = DEFAULT_MAX_LENGTH,
  localparam int unsigned COL_W = bits_for(len_cap(MAX_LENGTH)),
  localparam int unsigned ADDR_W = bits_for(MAX_LENGTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  action_t                  action,
  input  logic [IDX_W-1:0]         vector_index,
  input  logic signed [DATA_W-1:0] element_value,
  input  logic signed [DATA_W-1:0] self_value,
  input  logic [COL_W-1:0]         len_last,
  output logic                     row_last,
  output row_sum_t                 row
);

  logic [DATA_W-1:0] store [MAX_LENGTH];
  logic signed [DATA_W-1:0] rdata;

  logic [COL_W-1:0] col;
  logic             load_in_range;

  logic                     s1_valid;
  logic                     s1_load;
  logic                     s1_last;
  logic signed [DATA_W-1:0] s1_elem;
  logic signed [DATA_W-1:0] s1_self;

  logic                     s2_valid;
  logic                     s2_load;
  logic                     s2_last;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [DATA_W-1:0] s2_self;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sum;

  // Row ends when the column count reaches the last column
  assign row_last      = (action == ACT_MATRIX) && (col >= len_last);
  assign load_in_range = 32'(vector_index) < MAX_LENGTH;

  // Advance the column count
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (take) begin
      if (action == ACT_LOAD || row_last) begin
        col <= '0;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Vector store: write on load, read at the column on matrix requests
  always_ff @(posedge clk) begin
    if (take && action == ACT_LOAD && load_in_range) begin
      store[ADDR_W'(vector_index)] <= element_value;
    end
    if (take && action == ACT_MATRIX) begin
      rdata <= store[ADDR_W'(col)];
    end
  end

  // Stage 1: hold the request beside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    s1_load <= (action == ACT_LOAD);
    s1_last <= row_last;
    s1_elem <= element_value;
    s1_self <= self_value;
  end

  // Stage 2: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_load <= s1_load;
    s2_last <= s1_last;
    s2_prod <= s1_elem * rdata;
    s2_self <= s1_self;
  end

  assign acc_sum = acc + {{(ACC_W-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};

  // Stage 3: accumulate, clear on load and at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      row.valid <= 1'b0;
    end else begin
      row.valid <= s2_valid && !s2_load && s2_last;
      if (s2_valid) begin
        if (s2_load || s2_last) begin
          acc <= '0;
        end else begin
          acc <= acc_sum;
        end
      end
    end
    row.acc        <= acc_sum;
    row.self_value <= s2_self;
  end

endmodule

// File: sv/mvma_epi.sv
module mvma_epi
  import mvma_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] alpha_gain,
  input  logic signed [DATA_W-1:0] beta_gain,
  input  row_sum_t                 row,
  output result_t                  res
);

  localparam int unsigned SPLIT  = ACC_W / 2;
  localparam int unsigned HI_W   = DATA_W + ACC_W - SPLIT;
  localparam int unsigned LO_W   = DATA_W + SPLIT + 1;
  localparam int unsigned TOT_W  = 64;
  localparam int unsigned SHIFT  = 27;
  localparam int unsigned ALIGN  = 15;
  localparam int unsigned YW_W   = TOT_W - SHIFT;
  localparam logic signed [TOT_W-1:0] ROUND = TOT_W'(1) <<< (SHIFT - 1);
  localparam logic signed [YW_W-1:0]  Y_MAX = YW_W'(32767);
  localparam logic signed [YW_W-1:0]  Y_MIN = -YW_W'(32768);

  logic                      e1_valid;
  logic signed [HI_W-1:0]    p_hi;
  logic signed [LO_W-1:0]    p_lo;
  logic signed [PROD_W-1:0]  p_self;

  logic                      e2_valid;
  logic signed [TOT_W-1:0]   total;
  logic signed [YW_W-1:0]    y_wide;

  // Stage 1: split alpha*acc into two partial products, scale self
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else begin
      e1_valid <= row.valid;
    end
    p_hi   <= alpha_gain * $signed(row.acc[ACC_W-1:SPLIT]);
    p_lo   <= alpha_gain * $signed({1'b0, row.acc[SPLIT-1:0]});
    p_self <= beta_gain * row.self_value;
  end

  // Stage 2: align and sum with the rounding bias
  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else begin
      e2_valid <= e1_valid;
    end
    total <= (TOT_W'(p_hi) <<< SPLIT) + TOT_W'(p_lo)
           + (TOT_W'(p_self) <<< ALIGN) + ROUND;
  end

  assign y_wide = total[TOT_W-1:SHIFT];

  // Stage 3: clip to Q1.15
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= e2_valid;
    end
    if (y_wide > Y_MAX) begin
      res.y_value   <= DATA_W'(Y_MAX);
      res.saturated <= 1'b1;
    end else if (y_wide < Y_MIN) begin
      res.y_value   <= DATA_W'(Y_MIN);
      res.saturated <= 1'b1;
    end else begin
      res.y_value   <= y_wide[DATA_W-1:0];
      res.saturated <= 1'b0;
    end
  end

endmodule

// File: sv/matrix_vector_multiply_add_top.sv
// Fixed-point matrix-vector multiply-add: y[i] = beta*self[i] + alpha*sum_j A[i][j]*x[j].
//
// Input stream s_*: s_tuser selects the request kind (0 loads element_value into
// the vector store at vector_index and restarts the row, 1 streams one matrix
// element in row-major order). Each matrix element is multiplied by the stored
// vector element at the current column; the last column of a row yields one
// result on m_* (Q1.15 y_value in m_tdata, clip flag in m_tuser).
// Configuration: cfg_* writes alpha_gain, beta_gain or vector_length; it is always ready.
// The user must use it only while no request is in flight; the block does not enforce it.
//
// Throughput: one request per cycle while s_tready is high, loads and matrix elements alike. The
// vector store has one write and one read port with a registered read, and
// each request uses exactly one of them.
// A row's result reaches m_tvalid after its last element passes the registered steps in order:
// store read, multiply, accumulate, epilogue multiply, epilogue add, clip and
// the output queue write.
// Reset clears the column count, the accumulator and the output queue and
// restores the register defaults; the vector store is not cleared.
// When m_tready is low, results collect in an 8-entry output queue; s_tready
// drops only once eight results are accepted but not yet taken.
module matrix_vector_multiply_add_top
  import mvma_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = DEFAULT_MAX_LENGTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // vector_index, element_value, self_value, zero pad
  input  logic [0:0]           s_tuser,   // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // y_value
  output logic [0:0]           m_tuser,   // saturated
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int unsigned LEN_CAP = len_cap(MAX_LENGTH);
  localparam int unsigned COL_W   = bits_for(LEN_CAP);
  localparam int unsigned PTR_W   = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W   = $clog2(OUT_DEPTH + 1);

  // Clamp a length to the supported range and return its last column
  function automatic logic [COL_W-1:0] last_column(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > LEN_CAP) begin
      r = LEN_W'(LEN_CAP - 1);
    end else begin
      r = v - 1'b1;
    end
    return COL_W'(r);
  endfunction

  logic signed [DATA_W-1:0] alpha_gain;
  logic signed [DATA_W-1:0] beta_gain;
  logic [COL_W-1:0]         len_last;

  logic     s_take;
  logic     m_take;
  logic     row_last;
  row_sum_t row;
  result_t  res;

  logic [CNT_W-1:0]  pending;
  logic [CNT_W-1:0]  fifo_count;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [DATA_W-1:0] fifo_y   [OUT_DEPTH];
  logic              fifo_sat [OUT_DEPTH];

  assign cfg_ready = 1'b1;
  assign s_take    = s_tvalid && s_tready;
  assign m_take    = m_tvalid && m_tready;
  assign s_tready  = pending != CNT_W'(OUT_DEPTH);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= GAIN_RESET;
      beta_gain  <= GAIN_RESET;
      len_last   <= last_column(LEN_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALPHA:  alpha_gain <= cfg_data;
        REG_BETA:   beta_gain  <= cfg_data;
        REG_LENGTH: len_last   <= last_column(cfg_data[LEN_W-1:0]);
        default:    ;
      endcase
    end
  end

  mvma_core #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (s_take),
    .action       (action_t'(s_tuser[0])),
    .vector_index (s_tdata[IDX_W-1:0]),
    .element_value(s_tdata[IDX_W+DATA_W-1:IDX_W]),
    .self_value   (s_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W]),
    .len_last     (len_last),
    .row_last     (row_last),
    .row          (row)
  );

  mvma_epi u_epi (
    .clk       (clk),
    .rst       (rst),
    .alpha_gain(alpha_gain),
    .beta_gain (beta_gain),
    .row       (row),
    .res       (res)
  );

  // Reserve a queue slot for every row end taken, release it on delivery
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(s_take && row_last) - CNT_W'(m_take);
    end
  end

  // Output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      fifo_count <= '0;
    end else begin
      if (res.valid) begin
        tail <= tail + 1'b1;
      end
      if (m_take) begin
        head <= head + 1'b1;
      end
      fifo_count <= fifo_count + CNT_W'(res.valid) - CNT_W'(m_take);
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      fifo_y[tail]   <= res.y_value;
      fifo_sat[tail] <= res.saturated;
    end
  end

  assign m_tvalid   = fifo_count != '0;
  assign m_tdata    = fifo_y[head];
  assign m_tuser[0] = fifo_sat[head];

  // Reservations never exceed the queue
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(OUT_DEPTH))
    else $error("result reservations exceed the output queue");

  // Queued results were all reserved
  a_queue_reserved: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= pending)
    else $error("output queue holds an unreserved result");

  // A result never arrives at a full queue unless one leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (fifo_count != CNT_W'(OUT_DEPTH)) || m_take)
    else $error("result written into a full output queue");

  // Intake stops only when every slot is reserved
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $past(pending) == CNT_W'(OUT_DEPTH))
    else $error("intake stalled without a full reservation count");

endmodule

// File: tb/matrix_vector_multiply_add_top_test.sv
module matrix_vector_multiply_add_top_test;
  import mvma_pkg::*;

  localparam int unsigned PAD_W   = S_DATA_W - IDX_W - 2 * DATA_W;
  localparam int unsigned SETTLE  = 16;
  localparam int          PRELOAD_MAX = 64;
  localparam int          PHASE_ITEMS = 70;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One expected row result
  typedef struct packed {
    logic [DATA_W-1:0] y_value;
    logic              saturated;
  } row_out_t;

  // Predicts y = beta*self + alpha*(A*x) per completed row and checks the output stream
  class gemv_scoreboard;
    logic signed [DATA_W-1:0] x_store [DEFAULT_MAX_LENGTH];
    bit                       loaded [DEFAULT_MAX_LENGTH];
    int unsigned              col;
    logic [ACC_W-1:0]         acc;
    logic signed [DATA_W-1:0] alpha;
    logic signed [DATA_W-1:0] beta;
    logic [LEN_W-1:0]         len_reg;
    row_out_t                 rows_due[$];
    int                       errors;
    int                       requests_seen;
    int                       rows_checked;
    int                       clipped_seen;

    function new();
      col     = 0;
      acc     = '0;
      alpha   = GAIN_RESET;
      beta    = GAIN_RESET;
      len_reg = LEN_RESET;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_ALPHA:  alpha = val;
        REG_BETA:   beta = val;
        REG_LENGTH: len_reg = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp the length register to [1, MAX_LENGTH]
    function int unsigned row_length();
      int unsigned n;
      n = len_reg;
      if (n < 1) n = 1;
      if (n > DEFAULT_MAX_LENGTH) n = DEFAULT_MAX_LENGTH;
      return n;
    endfunction

    function void note_request(action_t act, logic [IDX_W-1:0] idx,
                               logic signed [DATA_W-1:0] elem,
                               logic signed [DATA_W-1:0] self_v);
      logic signed [PROD_W-1:0] prod;
      longint                   acc_s;
      longint                   total;
      longint                   y;
      row_out_t                 r;
      requests_seen++;
      // Load: write the store and restart the row
      if (act == ACT_LOAD) begin
        x_store[idx] = elem;
        loaded[idx]  = 1'b1;
        col = 0;
        acc = '0;
        return;
      end
      prod = elem * x_store[col];
      acc  = acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      if (col + 1 < row_length()) begin
        col++;
        return;
      end
      // Row end: scale, align, round half up, clip
      acc_s = $signed(acc);
      total = longint'(alpha) * acc_s + longint'(beta) * longint'(self_v) * 32768;
      y = (total + (longint'(1) << 26)) >>> 27;
      r.saturated = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.saturated = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.saturated = 1'b1;
      end
      r.y_value = DATA_W'(y);
      rows_due.push_back(r);
      col = 0;
      acc = '0;
    endfunction

    task report(string line);
      errors++;
      $display("ERROR: %s", line);
    endtask

    task check_result(logic [DATA_W-1:0] y_value, logic saturated);
      row_out_t r;
      if (rows_due.size() == 0) begin
        report($sformatf("result y=%0d with no row pending", $signed(y_value)));
        return;
      end
      r = rows_due.pop_front();
      rows_checked++;
      if (r.saturated) clipped_seen++;
      if (y_value !== r.y_value)
        report($sformatf("row %0d y_value got %0d, expected %0d", rows_checked,
                         $signed(y_value), $signed(r.y_value)));
      if (saturated !== r.saturated)
        report($sformatf("row %0d saturated got %0b, expected %0b", rows_checked,
                         saturated, r.saturated));
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]           s_tuser = ACT_LOAD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_W-1:0]    m_tdata;
  logic [0:0]           m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ALPHA;
  logic [DATA_W-1:0]    cfg_data = '0;

  gemv_scoreboard sb;
  bit             send_steady;
  bit             take_steady;
  int             settings_used;

  matrix_vector_multiply_add_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Favor extreme element values
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'd4096;
      4, 5:    return DATA_W'(int'($urandom_range(0, 16384)) - 8192);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Send one request, holding valid until it is taken
  task automatic send_request(action_t act, logic [IDX_W-1:0] idx,
                              logic [DATA_W-1:0] elem, logic [DATA_W-1:0] self_v);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, self_v, elem, idx};
    s_tuser  <= act;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_request(act, idx, elem, self_v);
  endtask

  // Drop valid and wait until every pending row result is back
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_register(idx, val);
  endtask

  // Idle the block, then write every register including the unmapped index
  task automatic configure(logic [DATA_W-1:0] alpha, logic [DATA_W-1:0] beta,
                           logic [LEN_W-1:0] len);
    hold_until_drained();
    write_register(REG_UNUSED, DATA_W'($urandom));
    write_register(REG_ALPHA, alpha);
    write_register(REG_BETA, beta);
    write_register(REG_LENGTH, {5'($urandom), len});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Fill the first columns in use, then stream rows mixed with occasional reloads
  task automatic run_phase(int n_items, int load_pct);
    int pause_at;
    pause_at = $urandom_range(0, n_items - 1);
    for (int i = 0; i < int'(sb.row_length()) && i < PRELOAD_MAX; i++)
      if (!sb.loaded[i]) send_request(ACT_LOAD, IDX_W'(i), pick_value(), pick_value());
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) hold_until_drained();
      if (int'($urandom_range(0, 99)) < load_pct || !sb.loaded[sb.col])
        send_request(ACT_LOAD, IDX_W'($urandom), pick_value(), pick_value());
      else
        send_request(ACT_MATRIX, IDX_W'($urandom), pick_value(), pick_value());
    end
  endtask

  // Result side: random stalls per result
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = take_steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_result(m_tdata, m_tuser[0]);
    end
  end

  initial begin
    logic [LEN_W-1:0] len;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extreme vector and matrix values, unit gains, three columns
    configure(16'd4096, 16'd4096, 11'd3);
    send_request(ACT_LOAD, 10'd0, 16'h7fff, 16'h8000);
    send_request(ACT_LOAD, 10'd1, 16'h8000, 16'h7fff);
    send_request(ACT_LOAD, 10'd2, 16'h0001, 16'h0000);
    send_request(ACT_LOAD, 10'd1023, 16'hffff, 16'hffff);
    send_request(ACT_MATRIX, 10'd0, 16'h8000, 16'h0000);
    send_request(ACT_MATRIX, 10'd1023, 16'h8000, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h7fff, 16'h7fff);
    send_request(ACT_MATRIX, 10'd0, 16'h7fff, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h7fff, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h7fff, 16'h8000);
    // A load in the middle of a row restarts it
    send_request(ACT_MATRIX, 10'd0, 16'h1234, 16'h0000);
    send_request(ACT_LOAD, 10'd2, 16'h8000, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h0001, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'hffff, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h0000, 16'hffff);

    // Most negative alpha, most positive beta
    configure(16'h8000, 16'h7fff, 11'd3);
    send_request(ACT_MATRIX, 10'd0, 16'h8000, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h8000, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h8000, 16'h8000);

    // Zero length clamps to one column; zero beta masks self
    configure(16'h7fff, 16'h0000, 11'd0);
    send_request(ACT_MATRIX, 10'd0, 16'h7fff, 16'h7fff);
    send_request(ACT_MATRIX, 10'd0, 16'h8000, 16'h1234);

    // Shorten the row while it is open: the next element closes it
    send_request(ACT_LOAD, 10'd3, 16'h4000, 16'h0000);
    configure(16'd4096, 16'd4096, 11'd4);
    send_request(ACT_MATRIX, 10'd0, 16'h2000, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h2000, 16'h0000);
    send_request(ACT_MATRIX, 10'd0, 16'h2000, 16'h0000);
    configure(16'd4096, 16'd4096, 11'd2);
    send_request(ACT_MATRIX, 10'd0, 16'h2000, 16'h0100);

    // Random phases; one of them uses the largest length, clamped to the store size
    for (int p = 0; p < 12; p++) begin
      send_steady = ($urandom_range(0, 3) == 0);
      take_steady = ($urandom_range(0, 3) == 0);
      if (p == 6) begin
        send_steady = 1'b1;
        take_steady = 1'b1;
        configure(pick_gain(), pick_gain(), 11'h7ff);
        run_phase(PHASE_ITEMS, 0);
      end else begin
        case ($urandom_range(0, 5))
          0:       len = 11'd1;
          1, 2, 3: len = LEN_W'($urandom_range(2, 8));
          4:       len = LEN_W'($urandom_range(9, 40));
          default: len = 11'd0;
        endcase
        configure(pick_gain(), pick_gain(), len);
        run_phase(PHASE_ITEMS, 8);
      end
    end

    send_steady = 1'b0;
    take_steady = 1'b0;
    hold_until_drained();
    $display("Run covered %0d requests, %0d row results (%0d clipped), %0d register settings.",
             sb.requests_seen, sb.rows_checked, sb.clipped_seen, settings_used);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
